// ----- design/rdb_pkg.sv -----
// Shared constants and control types for the radix-3 DIF butterfly.
`timescale 1ns / 1ps

package rdb_pkg;

    // Result field width; the magnitude bound keeps y0..y2 inside it
    localparam int OUT_W = 20;

    // Number of output fields and the byte-padded width of the result tdata
    localparam int OUT_FIELDS  = 6;
    localparam int OUT_TDATA_W = ((OUT_FIELDS * OUT_W + 7) / 8) * 8;

    // sqrt(3)/2 in Q15 and the shift that leaves one extra fraction bit
    localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;
    localparam int                 C_SHIFT        = 14;

    // Pipeline depth: three stages of pre-processing, two of multiplication
    localparam int NSTG = 5;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pre_en;

    typedef struct packed {
        logic prod;
        logic sum;
    } t_mul_en;

endpackage

// ----- design/rdb_pre.sv -----
// Butterfly front end: sums, sqrt(3)/2 scaling and the t1/t2 terms, three stages.
`timescale 1ns / 1ps

module rdb_pre #(
    parameter int DATA_WIDTH    = 16,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  rdb_pkg::t_pre_en              i_en,
    input  logic signed [DATA_WIDTH-1:0]  i_a0_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a0_im,
    input  logic signed [DATA_WIDTH-1:0]  i_a1_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a1_im,
    input  logic signed [DATA_WIDTH-1:0]  i_a2_re,
    input  logic signed [DATA_WIDTH-1:0]  i_a2_im,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w1_re,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w1_im,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w2_re,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w2_im,
    output logic signed [DATA_WIDTH+1:0]  o_y0_re,
    output logic signed [DATA_WIDTH+1:0]  o_y0_im,
    output logic signed [DATA_WIDTH+3:0]  o_t1_re,
    output logic signed [DATA_WIDTH+3:0]  o_t1_im,
    output logic signed [DATA_WIDTH+3:0]  o_t2_re,
    output logic signed [DATA_WIDTH+3:0]  o_t2_im,
    output logic signed [TWIDDLE_WIDTH-1:0] o_w1_re,
    output logic signed [TWIDDLE_WIDTH-1:0] o_w1_im,
    output logic signed [TWIDDLE_WIDTH-1:0] o_w2_re,
    output logic signed [TWIDDLE_WIDTH-1:0] o_w2_im
);
    import rdb_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int TW  = TWIDDLE_WIDTH;
    localparam int PW  = DW + 1;      // p, q
    localparam int BW  = DW + 2;      // 2*a0 - p, y0
    localparam int MQW = DW + 17;     // q * sqrt(3)/2 before rounding
    localparam int SW  = DW + 3;      // rounded scaled q
    localparam int TTW = DW + 4;      // t1, t2 at twice the input resolution

    localparam logic signed [MQW-1:0] C_RND = MQW'(1) << (C_SHIFT - 1);

    // stage 1
    logic signed [DW-1:0] r_a0_re, r_a0_im;
    logic signed [PW-1:0] r_p_re, r_p_im, r_q_re, r_q_im;
    logic signed [TW-1:0] r_w1_re1, r_w1_im1, r_w2_re1, r_w2_im1;
    // stage 2
    logic signed [BW-1:0]  r_b_re, r_b_im, r_y0_re2, r_y0_im2;
    logic signed [MQW-1:0] r_mq_re, r_mq_im;
    logic signed [TW-1:0]  r_w1_re2, r_w1_im2, r_w2_re2, r_w2_im2;
    // stage 3
    logic signed [BW-1:0]  r_y0_re3, r_y0_im3;
    logic signed [TTW-1:0] r_t1_re, r_t1_im, r_t2_re, r_t2_im;
    logic signed [TW-1:0]  r_w1_re3, r_w1_im3, r_w2_re3, r_w2_im3;

    logic signed [MQW-1:0] n_mqr_re, n_mqr_im;
    logic signed [SW-1:0]  n_s_re, n_s_im;
    logic signed [TTW-1:0] n_b_re, n_b_im;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_a0_re  <= i_a0_re;
            r_a0_im  <= i_a0_im;
            r_p_re   <= PW'(i_a1_re) + PW'(i_a2_re);
            r_p_im   <= PW'(i_a1_im) + PW'(i_a2_im);
            r_q_re   <= PW'(i_a1_re) - PW'(i_a2_re);
            r_q_im   <= PW'(i_a1_im) - PW'(i_a2_im);
            r_w1_re1 <= i_w1_re;
            r_w1_im1 <= i_w1_im;
            r_w2_re1 <= i_w2_re;
            r_w2_im1 <= i_w2_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_b_re   <= (BW'(r_a0_re) <<< 1) - BW'(r_p_re);
            r_b_im   <= (BW'(r_a0_im) <<< 1) - BW'(r_p_im);
            r_y0_re2 <= BW'(r_a0_re) + BW'(r_p_re);
            r_y0_im2 <= BW'(r_a0_im) + BW'(r_p_im);
            r_mq_re  <= MQW'(r_q_re) * MQW'(SQRT3_HALF_Q15);
            r_mq_im  <= MQW'(r_q_im) * MQW'(SQRT3_HALF_Q15);
            r_w1_re2 <= r_w1_re1;
            r_w1_im2 <= r_w1_im1;
            r_w2_re2 <= r_w2_re1;
            r_w2_im2 <= r_w2_im1;
        end
    end

    // round c*q to nearest, ties upward, keeping one extra fraction bit
    always_comb begin
        n_mqr_re = r_mq_re + C_RND;
        n_mqr_im = r_mq_im + C_RND;
        n_s_re   = n_mqr_re[C_SHIFT +: SW];
        n_s_im   = n_mqr_im[C_SHIFT +: SW];
        n_b_re   = TTW'(r_b_re);
        n_b_im   = TTW'(r_b_im);
    end

    // +/-j*c*q: real part takes c*q_im, imaginary part takes c*q_re
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_t1_re  <= n_b_re + TTW'(n_s_im);
            r_t1_im  <= n_b_im - TTW'(n_s_re);
            r_t2_re  <= n_b_re - TTW'(n_s_im);
            r_t2_im  <= n_b_im + TTW'(n_s_re);
            r_y0_re3 <= r_y0_re2;
            r_y0_im3 <= r_y0_im2;
            r_w1_re3 <= r_w1_re2;
            r_w1_im3 <= r_w1_im2;
            r_w2_re3 <= r_w2_re2;
            r_w2_im3 <= r_w2_im2;
        end
    end

    assign o_y0_re = r_y0_re3;
    assign o_y0_im = r_y0_im3;
    assign o_t1_re = r_t1_re;
    assign o_t1_im = r_t1_im;
    assign o_t2_re = r_t2_re;
    assign o_t2_im = r_t2_im;
    assign o_w1_re = r_w1_re3;
    assign o_w1_im = r_w1_im3;
    assign o_w2_re = r_w2_re3;
    assign o_w2_im = r_w2_im3;

endmodule

// ----- design/rdb_cmul.sv -----
// Two-stage complex multiply with a single round-to-nearest on the result.
`timescale 1ns / 1ps

module rdb_cmul #(
    parameter int DATA_WIDTH    = 16,
    parameter int TWIDDLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  rdb_pkg::t_mul_en                i_en,
    input  logic signed [DATA_WIDTH+3:0]    i_t_re,
    input  logic signed [DATA_WIDTH+3:0]    i_t_im,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w_re,
    input  logic signed [TWIDDLE_WIDTH-1:0] i_w_im,
    output logic signed [rdb_pkg::OUT_W-1:0] o_re,
    output logic signed [rdb_pkg::OUT_W-1:0] o_im
);
    import rdb_pkg::*;

    localparam int TW  = TWIDDLE_WIDTH;
    localparam int TTW = DATA_WIDTH + 4;
    localparam int PPW = TTW + TW;
    localparam int SMW = PPW + 1;

    localparam logic signed [SMW-1:0] RND_HALF = SMW'(1) << (TW - 1);

    logic signed [PPW-1:0]   r_rr, r_ii, r_ri, r_ir;
    logic signed [OUT_W-1:0] r_re, r_im;
    logic signed [SMW-1:0]   n_re, n_im;

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_rr <= PPW'(i_t_re) * PPW'(i_w_re);
            r_ii <= PPW'(i_t_im) * PPW'(i_w_im);
            r_ri <= PPW'(i_t_re) * PPW'(i_w_im);
            r_ir <= PPW'(i_t_im) * PPW'(i_w_re);
        end
    end

    always_comb begin
        n_re = SMW'(r_rr) - SMW'(r_ii) + RND_HALF;
        n_im = SMW'(r_ri) + SMW'(r_ir) + RND_HALF;
    end

    // drop the twiddle fraction bits; wider results wrap to the field
    always_ff @(posedge i_clk) begin
        if (i_en.sum) begin
            r_re <= OUT_W'(n_re >>> TW);
            r_im <= OUT_W'(n_im >>> TW);
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;

endmodule

// ----- design/radix3_dif_butterfly.sv -----
// Radix-3 DIF FFT butterfly with twiddles: top level, stream ports and pipeline control.
`timescale 1ns / 1ps

// Radix-3 decimation-in-frequency butterfly. Each transfer on the slave
// side carries a0, a1, a2 and the twiddles W1, W2 (Q1.15 at the default
// widths); the matching transfer on the master side carries
// y0 = a0 + a1 + a2, y1 = t1*W1 and y2 = t2*W2, where
// t1/t2 = a0 - (a1+a2)/2 -/+ j*sqrt(3)/2*(a1-a2). The t terms are held
// with one extra fraction bit and the complex products are rounded once to
// nearest (ties upward) back to input LSB units, as 20-bit signed fields.
// tlast passes through with its element. Throughput is one element per
// clock while the master side accepts; the five register stages are three of
// sums and sqrt(3)/2 scaling, one of products, one of sum and rounding.
// Valid bits travel with the data and empty stages fill while a later
// stage stalls, so back-pressure on the master side reaches the slave
// tready only once every stage holds an element. No state is kept between
// elements and reset only empties the pipeline.

module radix3_dif_butterfly #(
    parameter int DATA_WIDTH    = 16,
    parameter int TWIDDLE_WIDTH = 16,
    localparam int IN_TDATA_W   = ((6 * DATA_WIDTH + 4 * TWIDDLE_WIDTH + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // in0_re, in0_im, in1_re, in1_im, in2_re, in2_im (DATA_WIDTH each),
    // tw1_re, tw1_im, tw2_re, tw2_im (TWIDDLE_WIDTH each), zero padding
    input  logic [IN_TDATA_W-1:0]             i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,   // last_in
    // master side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // out0_re, out0_im, out1_re, out1_im, out2_re, out2_im (20 bits each)
    output logic [rdb_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast    // last_out
);
    import rdb_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int TW  = TWIDDLE_WIDTH;
    localparam int BW  = DW + 2;
    localparam int TTW = DW + 4;
    localparam int TWO = 6 * DW;   // first twiddle bit in tdata

    // pipeline control
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_last;
    logic [NSTG-1:0] w_lin;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_vin;
    logic [NSTG-1:0] w_en;
    t_pre_en         w_pre_en;
    t_mul_en         w_mul_en;

    // datapath between the front end and the multipliers
    logic signed [BW-1:0]    w_y0_re, w_y0_im;
    logic signed [TTW-1:0]   w_t1_re, w_t1_im, w_t2_re, w_t2_im;
    logic signed [TW-1:0]    w_w1_re, w_w1_im, w_w2_re, w_w2_im;
    logic signed [OUT_W-1:0] w_y1_re, w_y1_im, w_y2_re, w_y2_im;

    // y0 rides alongside the multiplier stages
    logic signed [BW-1:0]    r_y0_re4, r_y0_im4;
    logic signed [OUT_W-1:0] r_y0_re5, r_y0_im5;

    // A stage may load when it is empty or when the stage after it loads.
    always_comb begin
        w_rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_vin = {r_vld[NSTG-2:0], i_s_axis_tvalid};
    assign w_en  = w_rdy & w_vin;

    assign w_pre_en.s1   = w_en[0];
    assign w_pre_en.s2   = w_en[1];
    assign w_pre_en.s3   = w_en[2];
    assign w_mul_en.prod = w_en[3];
    assign w_mul_en.sum  = w_en[4];

    // Advance valid into every stage that loads; hold the ones that stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_rdy) | (w_vin & w_rdy);
        end
    end

    // tlast travels with its element through every stage
    assign w_lin = {r_last[NSTG-2:0], i_s_axis_tlast};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_last[k] <= w_lin[k];
            end
        end
    end

    rdb_pre #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_pre (
        .i_clk   (i_clk),
        .i_en    (w_pre_en),
        .i_a0_re (i_s_axis_tdata[0*DW +: DW]),
        .i_a0_im (i_s_axis_tdata[1*DW +: DW]),
        .i_a1_re (i_s_axis_tdata[2*DW +: DW]),
        .i_a1_im (i_s_axis_tdata[3*DW +: DW]),
        .i_a2_re (i_s_axis_tdata[4*DW +: DW]),
        .i_a2_im (i_s_axis_tdata[5*DW +: DW]),
        .i_w1_re (i_s_axis_tdata[TWO + 0*TW +: TW]),
        .i_w1_im (i_s_axis_tdata[TWO + 1*TW +: TW]),
        .i_w2_re (i_s_axis_tdata[TWO + 2*TW +: TW]),
        .i_w2_im (i_s_axis_tdata[TWO + 3*TW +: TW]),
        .o_y0_re (w_y0_re),
        .o_y0_im (w_y0_im),
        .o_t1_re (w_t1_re),
        .o_t1_im (w_t1_im),
        .o_t2_re (w_t2_re),
        .o_t2_im (w_t2_im),
        .o_w1_re (w_w1_re),
        .o_w1_im (w_w1_im),
        .o_w2_re (w_w2_re),
        .o_w2_im (w_w2_im)
    );

    rdb_cmul #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_cmul1 (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_t_re (w_t1_re),
        .i_t_im (w_t1_im),
        .i_w_re (w_w1_re),
        .i_w_im (w_w1_im),
        .o_re   (w_y1_re),
        .o_im   (w_y1_im)
    );

    rdb_cmul #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_cmul2 (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_t_re (w_t2_re),
        .i_t_im (w_t2_im),
        .i_w_re (w_w2_re),
        .i_w_im (w_w2_im),
        .o_re   (w_y2_re),
        .o_im   (w_y2_im)
    );

    // Delay y0 to line up with the products; size it to the result field.
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_y0_re4 <= w_y0_re;
            r_y0_im4 <= w_y0_im;
        end
        if (w_en[4]) begin
            r_y0_re5 <= OUT_W'(r_y0_re4);
            r_y0_im5 <= OUT_W'(r_y0_im4);
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tlast  = r_last[NSTG-1];

    always_comb begin
        o_m_axis_tdata                = '0;
        o_m_axis_tdata[0*OUT_W +: OUT_W] = r_y0_re5;
        o_m_axis_tdata[1*OUT_W +: OUT_W] = r_y0_im5;
        o_m_axis_tdata[2*OUT_W +: OUT_W] = w_y1_re;
        o_m_axis_tdata[3*OUT_W +: OUT_W] = w_y1_im;
        o_m_axis_tdata[4*OUT_W +: OUT_W] = w_y2_re;
        o_m_axis_tdata[5*OUT_W +: OUT_W] = w_y2_im;
    end

`ifndef SYNTH
    // Back-pressure reaches the input only when every stage is occupied.
    a_full_before_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld == {NSTG{1'b1}})
    ) else $error("input stalled with a bubble in the pipeline");

    // Occupancy changes only by transfers in and out: nothing lost or duplicated.
    a_occupancy: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) ==
             $countones($past(r_vld))
             + ($past(i_s_axis_tvalid && o_s_axis_tready) ? 1 : 0)
             - ($past(o_m_axis_tvalid && i_m_axis_tready) ? 1 : 0))
    ) else $error("pipeline occupancy does not match transfers");

    // A stalled output stage keeps its element.
    a_stall_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG-1] && !i_m_axis_tready) |=> (r_vld[NSTG-1] && $stable(r_last[NSTG-1]))
    ) else $error("stalled output stage lost its element");
`endif

endmodule

// ----- sim/radix3_dif_butterfly_checker.sv -----
// Stream checker for the radix-3 DIF butterfly: predicts each result and compares it.
`timescale 1ns / 1ps

module butterfly_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // in0_re, in0_im, in1_re, in1_im, in2_re, in2_im, tw1_re, tw1_im, tw2_re, tw2_im
    input  logic [159:0]                   i_s_tdata,
    input  logic                           i_s_tlast,  // last_in
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // out0_re, out0_im, out1_re, out1_im, out2_re, out2_im
    input  logic [rdb_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                           i_m_tlast,  // last_out
    output int                             o_fail_count,
    output int                             o_pending
);
    import rdb_pkg::*;

    localparam int D_W  = 16;
    localparam int TW_W = 16;

    typedef struct packed {
        logic [OUT_FIELDS-1:0][OUT_W-1:0] y;  // out0_re at index 0
        logic                             last;
    } t_butterfly_out;

    t_butterfly_out butterfly_out_q[$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    // c*q at one extra fraction bit, rounded to nearest, ties upward
    function automatic longint scale_sqrt3(longint q);
        return (q * longint'(SQRT3_HALF_Q15) + (longint'(1) <<< (C_SHIFT - 1))) >>> C_SHIFT;
    endfunction

    // drop the twiddle fraction bits and the extra bit of t, rounding to nearest
    function automatic logic [OUT_W-1:0] round_twiddle_product(longint x);
        longint r;
        r = (x + (longint'(1) <<< (TW_W - 1))) >>> TW_W;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_butterfly_out predict_butterfly(logic [159:0] d, logic tl);
        longint         v [10];
        longint         p_re, p_im, q_re, q_im, b_re, b_im, s_re, s_im;
        longint         t1_re, t1_im, t2_re, t2_im, y0_re, y0_im;
        t_butterfly_out r;
        for (int k = 0; k < 6; k++) v[k] = longint'($signed(d[D_W*k +: D_W]));
        for (int k = 0; k < 4; k++) v[6+k] = longint'($signed(d[6*D_W + TW_W*k +: TW_W]));
        p_re  = v[2] + v[4];
        p_im  = v[3] + v[5];
        q_re  = v[2] - v[4];
        q_im  = v[3] - v[5];
        b_re  = 2 * v[0] - p_re;
        b_im  = 2 * v[1] - p_im;
        // -j*c*q: real part takes c*q_im, imaginary part -c*q_re
        s_re  = scale_sqrt3(q_im);
        s_im  = scale_sqrt3(q_re);
        t1_re = b_re + s_re;
        t1_im = b_im - s_im;
        t2_re = b_re - s_re;
        t2_im = b_im + s_im;
        y0_re = v[0] + p_re;
        y0_im = v[1] + p_im;
        r.y[0] = y0_re[OUT_W-1:0];
        r.y[1] = y0_im[OUT_W-1:0];
        r.y[2] = round_twiddle_product(t1_re * v[6] - t1_im * v[7]);
        r.y[3] = round_twiddle_product(t1_re * v[7] + t1_im * v[6]);
        r.y[4] = round_twiddle_product(t2_re * v[8] - t2_im * v[9]);
        r.y[5] = round_twiddle_product(t2_re * v[9] + t2_im * v[8]);
        r.last = tl;
        return r;
    endfunction

    task automatic show_result(string label, t_butterfly_out r);
        $display("  %s y0=(%0d,%0d) y1=(%0d,%0d) y2=(%0d,%0d) last=%0b", label,
                 $signed(r.y[0]), $signed(r.y[1]), $signed(r.y[2]),
                 $signed(r.y[3]), $signed(r.y[4]), $signed(r.y[5]), r.last);
    endtask

    always @(posedge i_clk) begin
        t_butterfly_out want;
        t_butterfly_out got;
        logic           bad;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                butterfly_out_q.push_back(predict_butterfly(i_s_tdata, i_s_tlast));
            if (i_m_tvalid && i_m_tready) begin
                got.y    = i_m_tdata[OUT_FIELDS*OUT_W-1:0];
                got.last = i_m_tlast;
                if (butterfly_out_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: result with nothing outstanding", $time);
                        show_result("got     ", got);
                    end
                end else begin
                    want = butterfly_out_q.pop_front();
                    bad  = (got.last !== want.last);
                    for (int k = 0; k < OUT_FIELDS; k++)
                        if (got.y[k] !== want.y[k]) bad = 1'b1;
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result mismatch", $time);
                            show_result("expected", want);
                            show_result("got     ", got);
                        end
                    end
                end
            end
        end
        o_pending <= butterfly_out_q.size();
    end

endmodule

// ----- sim/tb_radix3_dif_butterfly.sv -----
// Testbench top for the radix-3 DIF butterfly: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_radix3_dif_butterfly;
    import rdb_pkg::*;

    localparam int N_RANDOM    = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 20;     // idle time after the final drain, beyond the five-stage pipeline
    localparam int LONG_HOLD   = 80;     // long enough to fill every stage
    localparam int MAXV        = 32767;
    localparam int MINV        = -32768;

    // ten 16-bit fields, in0_re at index 0, matching the slave tdata layout
    typedef logic [9:0][15:0] t_butterfly_in;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [159:0]           s_axis_tdata;   // in0_re .. tw2_im, 16 bits each
    logic                   s_axis_tlast;   // last_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // out0_re .. out2_im, 20 bits each
    logic                   m_axis_tlast;   // last_out

    int   fail_count;
    int   pending_results;
    int   cycle_count   = 0;
    bit   dense_traffic = 1'b0;  // no random idling on either side
    bit   hold_request  = 1'b0;  // ask the receiver for one long hold-off

    initial clk = 1'b0;
    always #10 clk = ~clk;

    radix3_dif_butterfly #(
        .DATA_WIDTH    (16),
        .TWIDDLE_WIDTH (16)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tlast  (m_axis_tlast)
    );

    butterfly_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tlast    (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // Give up on a hung pipeline or handshake
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_radix3_dif_butterfly failed");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Bias a share of the fields towards full scale and small values
    function automatic logic [15:0] rand_field();
        logic [15:0] v;
        case ($urandom_range(9))
            0:       v = 16'h8000;
            1:       v = 16'h7fff;
            2:       v = 16'($urandom_range(64)) - 16'd32;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_butterfly_in mk_item(int a0r, int a0i, int a1r, int a1i, int a2r,
                                              int a2i, int w1r, int w1i, int w2r, int w2i);
        t_butterfly_in f;
        f[0] = a0r[15:0];
        f[1] = a0i[15:0];
        f[2] = a1r[15:0];
        f[3] = a1i[15:0];
        f[4] = a2r[15:0];
        f[5] = a2i[15:0];
        f[6] = w1r[15:0];
        f[7] = w1i[15:0];
        f[8] = w2r[15:0];
        f[9] = w2i[15:0];
        return f;
    endfunction

    // Offer one element, hold it until the transfer, then idle for gap cycles
    task automatic send_item(t_butterfly_in f, logic tl, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tlast  <= tl;
        do @(posedge clk); while (!s_axis_tready);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every outstanding result to come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // Receiver: random stalls, none during dense traffic, one long hold-off on request
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!dense_traffic && $urandom_range(99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        t_butterfly_in f;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Zero, full scale of both signs and mixed extremes
        send_item(mk_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, pick_gap());
        send_item(mk_item(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV),
                  1'b0, pick_gap());
        send_item(mk_item(MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV),
                  1'b1, pick_gap());
        send_item(mk_item(MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV, MINV, MINV),
                  1'b0, pick_gap());
        send_item(mk_item(MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MAXV, MINV),
                  1'b1, pick_gap());
        // Largest difference a1 - a2 of both signs, to push t1 and t2 to their peaks
        send_item(mk_item(MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MINV, MAXV, MINV),
                  1'b0, pick_gap());
        send_item(mk_item(MINV, MAXV, MINV, MAXV, MAXV, MINV, MINV, MAXV, MAXV, MAXV),
                  1'b0, pick_gap());
        send_item(mk_item(MINV, MINV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MINV, MAXV),
                  1'b1, pick_gap());
        // Exact half in the sqrt(3)/2 scaling, both signs
        send_item(mk_item(0, 0, 4096, 4096, 0, 0, MAXV, 0, MAXV, 0), 1'b0, pick_gap());
        send_item(mk_item(0, 0, 0, 0, 4096, 4096, MAXV, 0, 0, MAXV), 1'b0, pick_gap());
        // Exact half in the real part of the product rounding, both signs
        send_item(mk_item(1, 0, 0, 0, 0, 0, 16384, 0, 16384, 0), 1'b0, pick_gap());
        send_item(mk_item(-1, 0, 0, 0, 0, 0, 16384, 0, 16384, 0), 1'b1, pick_gap());
        send_item(mk_item(0, 1, 0, 0, 0, 0, 0, 16384, 0, 16384), 1'b0, pick_gap());
        send_item(mk_item(0, -1, 0, 0, 0, 0, 0, 16384, 0, 16384), 1'b0, pick_gap());
        // Twiddles of -1 and -j, plain all-ones data
        send_item(mk_item(1000, -2000, 300, 400, -500, 600, MINV, 0, 0, MINV), 1'b1, pick_gap());
        send_item(mk_item(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b1, pick_gap());
        wait_for_drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            dense_traffic = (n >= 600 && n < 800) || (n >= 1400 && n < 1500);
            // receiver holds off while the sender keeps offering: the pipeline fills
            if (n == 620) hold_request = 1'b1;
            if (n == 1000) wait_for_drain();
            for (int k = 0; k < 10; k++) f[k] = rand_field();
            send_item(f, ($urandom_range(7) == 0), dense_traffic ? 0 : pick_gap());
        end

        wait_for_drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("tb_radix3_dif_butterfly passed");
        else
            $display("tb_radix3_dif_butterfly failed");
        $finish;
    end

endmodule
